>>> hdl/ofifo_pkg.sv
// ----------------------------------------------------------------------------
// ofifo_pkg
// Shared types and constants for the overwriting frame fifo.
// ----------------------------------------------------------------------------
package ofifo_pkg;

    localparam int MAX_FRAMES   = 1024;
    localparam int MAX_CHANNELS = 8;

    localparam int SAMPLE_W = 32;
    localparam int IDX_W    = $clog2(MAX_FRAMES);
    localparam int FILL_W   = 11;
    localparam int CAP_W    = 11;
    localparam int CHAN_W   = 4;
    localparam int KIND_W   = 2;
    localparam int REG_W    = 2;
    localparam int CFG_W    = 11;

    // clamp limits for the configuration registers
    localparam logic [CHAN_W-1:0] CHAN_MAX = CHAN_W'(MAX_CHANNELS);
    localparam logic [CAP_W-1:0]  CAP_MAX  = CAP_W'(MAX_FRAMES);

    // item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH  = 2'd0,
        KIND_POP   = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NOP   = 2'd3
    } kind_t;

    // configuration register indexes
    localparam logic [REG_W-1:0] REG_CHANNELS = 2'd0;
    localparam logic [REG_W-1:0] REG_CAPACITY = 2'd1;

    typedef logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] frame_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic cfg_we;
    } ofifo_cmd_t;

endpackage

>>> hdl/ofifo_ram.sv
// ----------------------------------------------------------------------------
// ofifo_ram
// Generic simple dual-port ram, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ofifo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/ofifo_ctrl.sv
// ----------------------------------------------------------------------------
// ofifo_ctrl
// Sequencer: accept a transaction, run it through the datapath, hold result.
// ----------------------------------------------------------------------------
module ofifo_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    output ofifo_pkg::ofifo_cmd_t cmd
);
    import ofifo_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // next state
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next     = ST_RESP;
                out_valid_next = 1'b1;
            end
            ST_RESP:
            begin
                if (!out_stall)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b0;
                end
            end
            default:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b0;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign cfg_ready   = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign cmd.capture = in_valid && (state_reg == ST_IDLE);
    assign cmd.exec    = (state_reg == ST_EXEC);
    assign cmd.cfg_we  = cfg_valid && (state_reg == ST_IDLE);

endmodule

>>> hdl/ofifo_dp.sv
// ----------------------------------------------------------------------------
// ofifo_dp
// Datapath: ring indexes, fill count, per-lane sample rams and result regs.
// ----------------------------------------------------------------------------
module ofifo_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ofifo_pkg::ofifo_cmd_t         cmd,
    input  logic [ofifo_pkg::KIND_W-1:0]  kind,
    input  ofifo_pkg::frame_t             in_frame,
    input  logic [ofifo_pkg::REG_W-1:0]   cfg_index,
    input  logic [ofifo_pkg::CFG_W-1:0]   cfg_data,
    output ofifo_pkg::frame_t             out_frame,
    output logic                          frame_valid,
    output logic                          dropped_oldest,
    output logic [ofifo_pkg::FILL_W-1:0]  fill_frames
);
    import ofifo_pkg::*;

    // configuration and ring state
    logic [CHAN_W-1:0] chan_reg, chan_next;
    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]  wr_idx_reg, wr_idx_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    // captured item and results
    kind_t             kind_reg;
    frame_t            samp_reg;
    frame_t            out_frame_reg, out_frame_next;
    logic              valid_reg, valid_next;
    logic              dropped_reg, dropped_next;

    logic [IDX_W-1:0]  rd_eff;
    logic [IDX_W-1:0]  wr_eff;
    logic [IDX_W-1:0]  rd_inc;
    logic [IDX_W-1:0]  wr_inc;
    logic [CAP_W-1:0]  rd_sum;
    logic [CAP_W-1:0]  wr_sum;
    logic              full;
    logic              push_we;
    frame_t            ram_rdata;
    logic [CHAN_W-1:0] cfg_chan;
    logic [CAP_W-1:0]  cfg_cap;

    // indexes wrapped into the current capacity
    assign rd_eff = ({1'b0, rd_idx_reg} >= cap_reg) ? '0 : rd_idx_reg;
    assign wr_eff = ({1'b0, wr_idx_reg} >= cap_reg) ? '0 : wr_idx_reg;
    assign rd_sum = {1'b0, rd_eff} + CAP_W'(1);
    assign wr_sum = {1'b0, wr_eff} + CAP_W'(1);
    assign rd_inc = (rd_sum == cap_reg) ? '0 : rd_sum[IDX_W-1:0];
    assign wr_inc = (wr_sum == cap_reg) ? '0 : wr_sum[IDX_W-1:0];
    assign full   = (fill_reg >= cap_reg);

    assign push_we = cmd.exec && (kind_reg == KIND_PUSH);

    // clamped register values
    always_comb
    begin
        cfg_chan = cfg_data[CHAN_W-1:0];
        if (cfg_chan == '0)
        begin
            cfg_chan = CHAN_W'(1);
        end
        else if (cfg_chan > CHAN_MAX)
        begin
            cfg_chan = CHAN_MAX;
        end
        cfg_cap = cfg_data[CAP_W-1:0];
        if (cfg_cap == '0)
        begin
            cfg_cap = CAP_W'(1);
        end
        else if (cfg_cap > CAP_MAX)
        begin
            cfg_cap = CAP_MAX;
        end
    end

    // one ram per lane, read at the head while the item is captured
    for (genvar g = 0; g < MAX_CHANNELS; g++)
    begin : g_lane
        ofifo_ram #(
            .WIDTH (SAMPLE_W),
            .DEPTH (MAX_FRAMES)
        ) u_ram (
            .clk   (clk),
            .we    (push_we && (CHAN_W'(g) < chan_reg)),
            .waddr (wr_eff),
            .wdata (samp_reg[g]),
            .raddr (rd_eff),
            .rdata (ram_rdata[g])
        );
    end

    // item execution and configuration
    always_comb
    begin
        chan_next      = chan_reg;
        cap_next       = cap_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        fill_next      = fill_reg;
        out_frame_next = out_frame_reg;
        valid_next     = valid_reg;
        dropped_next   = dropped_reg;
        if (cmd.exec)
        begin
            out_frame_next = '0;
            valid_next     = 1'b0;
            dropped_next   = 1'b0;
            unique case (kind_reg)
                KIND_PUSH:
                begin
                    // full: oldest frame is dropped, fill stays at capacity
                    if (full)
                    begin
                        dropped_next = 1'b1;
                        rd_idx_next  = rd_inc;
                        fill_next    = cap_reg;
                    end
                    else
                    begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    wr_idx_next = wr_inc;
                end
                KIND_POP:
                begin
                    if (fill_reg != '0)
                    begin
                        for (int i = 0; i < MAX_CHANNELS; i++)
                        begin
                            if (CHAN_W'(i) < chan_reg)
                            begin
                                out_frame_next[i] = ram_rdata[i];
                            end
                        end
                        valid_next  = 1'b1;
                        rd_idx_next = rd_inc;
                        fill_next   = fill_reg - FILL_W'(1);
                    end
                end
                KIND_CLEAR:
                begin
                    rd_idx_next = '0;
                    wr_idx_next = '0;
                    fill_next   = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.cfg_we)
        begin
            if (cfg_index == REG_CHANNELS)
            begin
                chan_next   = cfg_chan;
                rd_idx_next = '0;
                wr_idx_next = '0;
                fill_next   = '0;
            end
            else if (cfg_index == REG_CAPACITY)
            begin
                cap_next    = cfg_cap;
                rd_idx_next = '0;
                wr_idx_next = '0;
                fill_next   = '0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg    <= CHAN_W'(1);
            cap_reg     <= CAP_MAX;
            rd_idx_reg  <= '0;
            wr_idx_reg  <= '0;
            fill_reg    <= '0;
            valid_reg   <= 1'b0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            chan_reg    <= chan_next;
            cap_reg     <= cap_next;
            rd_idx_reg  <= rd_idx_next;
            wr_idx_reg  <= wr_idx_next;
            fill_reg    <= fill_next;
            valid_reg   <= valid_next;
            dropped_reg <= dropped_next;
        end
    end

    // payload capture and result words
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind_t'(kind);
            samp_reg <= in_frame;
        end
        out_frame_reg <= out_frame_next;
    end

    assign out_frame      = out_frame_reg;
    assign frame_valid    = valid_reg;
    assign dropped_oldest = dropped_reg;
    assign fill_frames    = fill_reg;

    // fill level never runs past the configured capacity
    a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= cap_reg)
        else $error("fill count above capacity");

    // a dropped frame means the fifo is left exactly full
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dropped_reg) |-> (fill_reg == cap_reg))
        else $error("drop flagged without full fifo");

    // a result never flags both a returned frame and a drop
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(valid_reg && dropped_reg))
        else $error("frame_valid and dropped_oldest both set");

    // a successful pop lowers the fill level by one
    a_pop_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && kind_reg == KIND_POP && fill_reg != '0)
        |=> (fill_reg == $past(fill_reg) - FILL_W'(1)))
        else $error("pop did not lower fill level");

endmodule

>>> hdl/overwriting_frame_fifo_top.sv
// ----------------------------------------------------------------------------
// overwriting_frame_fifo_top
// Multichannel audio frame fifo that overwrites its oldest frame when full.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries kind and in_sample_0..7:
//   push one frame, pop one frame, clear the fifo or do nothing (nop). Each transaction gives
//   exactly one result on the output channel (out_valid / out_stall):
//   out_sample_0..7, frame_valid, dropped_oldest and fill_frames.
//   Configuration writes (cfg_valid / cfg_ready, cfg_index, cfg_data) set
//   lanes in use (index 0) or capacity in frames (index 1); either write
//   empties the fifo. Out of range values are clamped, the lane count
//   from cfg_data[3:0] only. Timing: an item is accepted in the idle
//   state, the lane rams are read and the ring state updated in the exec
//   state, and the result is presented in the response state. The sequencer
//   handles one item at a time; the registered ram read is why the exec
//   state precedes the result. in_stall and cfg_ready follow the sequencer.
//   While out_stall is high the result holds and no new item is accepted.
//   Reset: fifo empty, one lane in use, capacity 1024 frames; the sample
//   rams are not cleared, stored frames only are ever read back.
// ----------------------------------------------------------------------------
module overwriting_frame_fifo_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ofifo_pkg::KIND_W-1:0]    kind,
    input  logic [ofifo_pkg::SAMPLE_W-1:0]  in_sample_0,
    input  logic [ofifo_pkg::SAMPLE_W-1:0]  in_sample_1,
    input  logic [ofifo_pkg::SAMPLE_W-1:0]  in_sample_2,
    input  logic [ofifo_pkg::SAMPLE_W-1:0]  in_sample_3,
    input  logic [ofifo_pkg::SAMPLE_W-1:0]  in_sample_4,
    input  logic [ofifo_pkg::SAMPLE_W-1:0]  in_sample_5,
    input  logic [ofifo_pkg::SAMPLE_W-1:0]  in_sample_6,
    input  logic [ofifo_pkg::SAMPLE_W-1:0]  in_sample_7,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ofifo_pkg::SAMPLE_W-1:0]  out_sample_0,
    output logic [ofifo_pkg::SAMPLE_W-1:0]  out_sample_1,
    output logic [ofifo_pkg::SAMPLE_W-1:0]  out_sample_2,
    output logic [ofifo_pkg::SAMPLE_W-1:0]  out_sample_3,
    output logic [ofifo_pkg::SAMPLE_W-1:0]  out_sample_4,
    output logic [ofifo_pkg::SAMPLE_W-1:0]  out_sample_5,
    output logic [ofifo_pkg::SAMPLE_W-1:0]  out_sample_6,
    output logic [ofifo_pkg::SAMPLE_W-1:0]  out_sample_7,
    output logic                            frame_valid,
    output logic                            dropped_oldest,
    output logic [ofifo_pkg::FILL_W-1:0]    fill_frames,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ofifo_pkg::REG_W-1:0]     cfg_index,
    input  logic [ofifo_pkg::CFG_W-1:0]     cfg_data
);
    import ofifo_pkg::*;

    ofifo_cmd_t cmd;
    frame_t     in_frame;
    frame_t     out_frame;

    // gather lanes into one frame
    assign in_frame[0] = in_sample_0;
    assign in_frame[1] = in_sample_1;
    assign in_frame[2] = in_sample_2;
    assign in_frame[3] = in_sample_3;
    assign in_frame[4] = in_sample_4;
    assign in_frame[5] = in_sample_5;
    assign in_frame[6] = in_sample_6;
    assign in_frame[7] = in_sample_7;

    // sequencer
    ofifo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    // ring buffer datapath
    ofifo_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .kind           (kind),
        .in_frame       (in_frame),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_frame      (out_frame),
        .frame_valid    (frame_valid),
        .dropped_oldest (dropped_oldest),
        .fill_frames    (fill_frames)
    );

    // spread the result frame onto lane ports
    assign out_sample_0 = out_frame[0];
    assign out_sample_1 = out_frame[1];
    assign out_sample_2 = out_frame[2];
    assign out_sample_3 = out_frame[3];
    assign out_sample_4 = out_frame[4];
    assign out_sample_5 = out_frame[5];
    assign out_sample_6 = out_frame[6];
    assign out_sample_7 = out_frame[7];

endmodule
